### src/sfb_pkg.sv
package sfb_pkg;

   localparam int TICK_BITS_DEFAULT = 16;

   // Depth of the job queue between the front and back ends.
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // A shield header expands into this many host bytes.
   localparam int HDR_LEN = 4;
   localparam int HDR_CNT_W = $clog2(HDR_LEN);

   localparam int CFG_W = 16;
   localparam int CFG_IDX_W = 2;

   localparam logic [CFG_IDX_W-1:0] CSR_BOARD_ID      = 2'd0;
   localparam logic [CFG_IDX_W-1:0] CSR_FRAME_TIMEOUT = 2'd1;
   localparam logic [CFG_IDX_W-1:0] CSR_LED_WINDOW    = 2'd2;
   localparam logic [CFG_IDX_W-1:0] CSR_LED_FLASH     = 2'd3;

   localparam logic [3:0]  BOARD_ID_RESET      = 4'd0;
   localparam logic [15:0] FRAME_TIMEOUT_RESET = 16'd4000;
   localparam logic [15:0] LED_WINDOW_RESET    = 16'd60000;
   localparam logic [15:0] LED_FLASH_RESET     = 16'd250;

   localparam logic [7:0] CHAR_LBRACK = 8'h5B;
   localparam logic [7:0] CHAR_RBRACK = 8'h5D;
   localparam logic [7:0] CHAR_LPAREN = 8'h28;
   localparam logic [7:0] CHAR_RPAREN = 8'h29;
   localparam logic [7:0] CHAR_LBRACE = 8'h7B;
   localparam logic [7:0] CHAR_RBRACE = 8'h7D;
   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_NINE   = 8'h39;
   localparam logic [7:0] CHAR_UP_A   = 8'h41;
   localparam logic [7:0] CHAR_UP_F   = 8'h46;
   localparam logic [7:0] CHAR_LO_A   = 8'h61;
   localparam logic [7:0] CHAR_LO_F   = 8'h66;

   typedef enum logic [1:0] {
      CMD_HOST       = 2'd0,
      CMD_SHIELD     = 2'd1,
      CMD_TICK       = 2'd2,
      CMD_LED_ENABLE = 2'd3
   } cmd_type;

   typedef enum logic [4:0] {
      PH_IDLE    = 5'b00001,
      PH_HEADER  = 5'b00010,
      PH_VERSION = 5'b00100,
      PH_ID1     = 5'b01000,
      PH_PAYLOAD = 5'b10000
   } phase_type;

   // One classified transaction waiting for the back end.
   typedef struct packed {
      logic       multi;
      logic       accepted;
      logic       byte_valid;
      logic       out_dest;
      logic [7:0] out_byte;
      logic       rx_led_lit;
      logic       tx_led_lit;
   } job_type;

   typedef struct packed {
      logic       accepted;
      logic       byte_valid;
      logic       out_dest;
      logic [7:0] out_byte;
      logic       last;
      logic       rx_led_lit;
      logic       tx_led_lit;
   } rsp_type;

   // Bit 4 set means the byte is not a hex digit.
   function automatic logic [4:0] hex_decode(logic [7:0] c);
      logic [4:0] r;
      if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
         r = 5'(c - CHAR_ZERO);
      end else if (c >= CHAR_LO_A && c <= CHAR_LO_F) begin
         r = 5'(c - CHAR_LO_A + 8'd10);
      end else if (c >= CHAR_UP_A && c <= CHAR_UP_F) begin
         r = 5'(c - CHAR_UP_A + 8'd10);
      end else begin
         r = 5'h10;
      end
      return r;
   endfunction

   function automatic logic [7:0] hex_char(logic [3:0] v);
      logic [7:0] r;
      if (v < 4'd10) begin
         r = CHAR_ZERO + {4'd0, v};
      end else begin
         r = CHAR_UP_A + {4'd0, v} - 8'd10;
      end
      return r;
   endfunction

endpackage

### src/sfb_if.sv
interface sfb_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] command;
   logic [7:0] data_byte;

   modport source (output valid, output command, output data_byte, input ready);
   modport sink (input valid, input command, input data_byte, output ready);
endinterface

interface sfb_rsp_if;
   logic       valid;
   logic       ready;
   logic       accepted;
   logic       byte_valid;
   logic       out_dest;
   logic [7:0] out_byte;
   logic       last;
   logic       rx_led_lit;
   logic       tx_led_lit;

   modport source (output valid, output accepted, output byte_valid, output out_dest,
                   output out_byte, output last, output rx_led_lit, output tx_led_lit,
                   input ready);
   modport sink (input valid, input accepted, input byte_valid, input out_dest,
                 input out_byte, input last, input rx_led_lit, input tx_led_lit,
                 output ready);
endinterface

### src/serial_frame_bridge_unit.sv
// Channel    Role    Payload                                        Accepted when
// req_chan   sink    command, data_byte                             valid && ready
// rsp_chan   source  accepted, byte_valid, out_dest, out_byte,      valid && ready
//                    last, rx_led_lit, tx_led_lit
// csr_*      write   csr_index, csr_wdata                           csr_we
//
// The front end takes one transaction per cycle while the job queue has room; it
// updates the frame, tick and LED state in that same cycle. The back end issues one
// response per cycle from its output register unless rsp_chan stalls; a shield '{'
// yields four responses and other jobs one, set by the single response port.
// Reset is synchronous and active high; it restores the register defaults.
// A stalled response port fills the queue, after which req_chan.ready drops.
module serial_frame_bridge_unit #(
   parameter int TICK_BITS = sfb_pkg::TICK_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   sfb_req_if.sink                       req_chan,
   sfb_rsp_if.source                     rsp_chan,
   input  logic                          csr_we,
   input  logic [sfb_pkg::CFG_IDX_W-1:0] csr_index,
   input  logic [sfb_pkg::CFG_W-1:0]     csr_wdata
);

   // Classified transactions flow from the front end through the queue.
   sfb_pkg::job_type front_job, head_job;
   sfb_pkg::rsp_type rsp_data;
   logic             push, pop, q_empty, q_full;

   assign req_chan.ready = !q_full;

   sfb_front #(
      .TICK_BITS(TICK_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_chan.valid),
      .command    (req_chan.command),
      .data_byte  (req_chan.data_byte),
      .queue_full (q_full),
      .push       (push),
      .job        (front_job),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   sfb_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .wr_data (front_job),
      .pop     (pop),
      .rd_data (head_job),
      .empty   (q_empty),
      .full    (q_full)
   );

   // The back end expands each job into its responses, one per cycle while rsp_chan.ready allows.
   sfb_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head_job),
      .empty     (q_empty),
      .pop       (pop),
      .out_ready (rsp_chan.ready),
      .out_valid (rsp_chan.valid),
      .out_data  (rsp_data)
   );

   assign rsp_chan.accepted   = rsp_data.accepted;
   assign rsp_chan.byte_valid = rsp_data.byte_valid;
   assign rsp_chan.out_dest   = rsp_data.out_dest;
   assign rsp_chan.out_byte   = rsp_data.out_byte;
   assign rsp_chan.last       = rsp_data.last;
   assign rsp_chan.rx_led_lit = rsp_data.rx_led_lit;
   assign rsp_chan.tx_led_lit = rsp_data.tx_led_lit;

   // The output register comes up empty out of reset.
   a_reset_clears_output: assert property (@(posedge clock)
      reset |=> !rsp_chan.valid)
      else $error("response valid after reset");

   // A transaction written into an empty queue is still there in the next cycle.
   a_push_lands: assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready && q_empty |=> !q_empty)
      else $error("accepted transaction lost");

   // While a header expansion is partly sent, its job stays at the queue head.
   a_header_held: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.last |-> !q_empty)
      else $error("header job popped before its final response");

   // Refused shield bytes never carry a byte to send.
   a_refused_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.accepted |-> !rsp_chan.byte_valid && rsp_chan.last)
      else $error("refused transaction produced a byte");

endmodule

### src/sfb_front.sv
module sfb_front #(
   parameter int TICK_BITS = sfb_pkg::TICK_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  logic [1:0]                    command,
   input  logic [7:0]                    data_byte,
   input  logic                          queue_full,
   output logic                          push,
   output sfb_pkg::job_type              job,
   input  logic                          csr_we,
   input  logic [sfb_pkg::CFG_IDX_W-1:0] csr_index,
   input  logic [sfb_pkg::CFG_W-1:0]     csr_wdata
);

   localparam int CMP_W = (TICK_BITS > sfb_pkg::CFG_W) ? TICK_BITS : sfb_pkg::CFG_W;

   logic [3:0]               board_id_ff;
   logic [sfb_pkg::CFG_W-1:0] frame_timeout_ff, led_window_ff, led_flash_ff;

   sfb_pkg::phase_type phase_ff, phase_in, host_ph;
   logic [3:0]           id_hi_ff, id_hi_in;
   logic [TICK_BITS-1:0] tick_ff, tick_in;
   logic [TICK_BITS-1:0] frame_start_ff, frame_start_in;
   logic [TICK_BITS-1:0] rx_start_ff, rx_start_in;
   logic [TICK_BITS-1:0] tx_start_ff, tx_start_in;
   logic [TICK_BITS-1:0] en_start_ff, en_start_in;
   logic                 leds_en_ff, leds_en_in;
   logic                 rx_on_ff, rx_on_in;
   logic                 tx_on_ff, tx_on_in;

   logic [TICK_BITS-1:0] tick_next, el_frame, el_en, el_rx, el_tx;
   logic                 frame_stale;
   logic [4:0]           hex;
   logic [7:0]           c;

   assign push      = in_valid && !queue_full;
   assign c         = data_byte;
   assign hex       = sfb_pkg::hex_decode(c);
   assign tick_next = tick_ff + 1'b1;
   assign el_frame  = tick_ff - frame_start_ff;
   assign el_en     = tick_next - en_start_ff;
   assign el_rx     = tick_next - rx_start_ff;
   assign el_tx     = tick_next - tx_start_ff;
   assign frame_stale = CMP_W'(el_frame) > CMP_W'(frame_timeout_ff);

   always_comb begin
      host_ph = phase_ff;
      if (c == sfb_pkg::CHAR_LBRACK) begin
         host_ph = sfb_pkg::PH_IDLE;
      end
      if (host_ph != sfb_pkg::PH_IDLE && frame_stale) begin
         host_ph = sfb_pkg::PH_IDLE;
      end
   end

   always_comb begin
      phase_in       = phase_ff;
      id_hi_in       = id_hi_ff;
      tick_in        = tick_ff;
      frame_start_in = frame_start_ff;
      rx_start_in    = rx_start_ff;
      tx_start_in    = tx_start_ff;
      en_start_in    = en_start_ff;
      leds_en_in     = leds_en_ff;
      rx_on_in       = rx_on_ff;
      tx_on_in       = tx_on_ff;
      job            = '0;
      job.accepted   = 1'b1;

      unique case (sfb_pkg::cmd_type'(command))
         sfb_pkg::CMD_HOST: begin
            phase_in = host_ph;
            unique case (host_ph)
               sfb_pkg::PH_IDLE: begin
                  if (c == sfb_pkg::CHAR_LBRACK) begin
                     phase_in       = sfb_pkg::PH_HEADER;
                     frame_start_in = tick_ff;
                  end
               end
               sfb_pkg::PH_HEADER: begin
                  phase_in = (c == sfb_pkg::CHAR_ZERO) ? sfb_pkg::PH_VERSION
                                                       : sfb_pkg::PH_IDLE;
               end
               sfb_pkg::PH_VERSION: begin
                  if (!hex[4]) begin
                     id_hi_in = hex[3:0];
                     phase_in = sfb_pkg::PH_ID1;
                  end else begin
                     phase_in = sfb_pkg::PH_IDLE;
                  end
               end
               sfb_pkg::PH_ID1: begin
                  // Ids above 0x0F never match.
                  if (!hex[4] && id_hi_ff == 4'd0 && hex[3:0] == board_id_ff) begin
                     phase_in       = sfb_pkg::PH_PAYLOAD;
                     job.byte_valid = 1'b1;
                     job.out_byte   = sfb_pkg::CHAR_LBRACE;
                  end else begin
                     phase_in = sfb_pkg::PH_IDLE;
                  end
               end
               sfb_pkg::PH_PAYLOAD: begin
                  job.byte_valid = 1'b1;
                  if (c == sfb_pkg::CHAR_RBRACK) begin
                     phase_in     = sfb_pkg::PH_IDLE;
                     job.out_byte = sfb_pkg::CHAR_RBRACE;
                     if (leds_en_ff) begin
                        rx_start_in = tick_ff;
                        rx_on_in    = 1'b1;
                     end
                  end else begin
                     job.out_byte = c;
                  end
               end
               default: begin
                  phase_in = sfb_pkg::PH_IDLE;
               end
            endcase
         end
         sfb_pkg::CMD_SHIELD: begin
            if (phase_ff != sfb_pkg::PH_IDLE) begin
               job.accepted = 1'b0;
            end else begin
               job.byte_valid = 1'b1;
               job.out_dest   = 1'b1;
               if (c == sfb_pkg::CHAR_LBRACE) begin
                  job.multi    = 1'b1;
                  job.out_byte = sfb_pkg::hex_char(board_id_ff);
               end else if (c == sfb_pkg::CHAR_RBRACE) begin
                  job.out_byte = sfb_pkg::CHAR_RPAREN;
                  if (leds_en_ff) begin
                     tx_start_in = tick_ff;
                     tx_on_in    = 1'b1;
                  end
               end else begin
                  job.out_byte = c;
               end
            end
         end
         sfb_pkg::CMD_TICK: begin
            tick_in = tick_next;
            if (leds_en_ff) begin
               if (CMP_W'(el_en) > CMP_W'(led_window_ff)) begin
                  leds_en_in = 1'b0;
               end
               if (tx_on_ff && CMP_W'(el_tx) > CMP_W'(led_flash_ff)) begin
                  tx_on_in = 1'b0;
               end
               if (rx_on_ff && CMP_W'(el_rx) > CMP_W'(led_flash_ff)) begin
                  rx_on_in = 1'b0;
               end
            end else begin
               tx_on_in = 1'b0;
               rx_on_in = 1'b0;
            end
         end
         sfb_pkg::CMD_LED_ENABLE: begin
            en_start_in = tick_ff;
            leds_en_in  = 1'b1;
         end
         default: begin
            job.accepted = 1'b1;
         end
      endcase

      job.rx_led_lit = rx_on_in;
      job.tx_led_lit = tx_on_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= sfb_pkg::PH_IDLE;
         id_hi_ff       <= 4'hF;
         tick_ff        <= '0;
         frame_start_ff <= '0;
         rx_start_ff    <= '0;
         tx_start_ff    <= '0;
         en_start_ff    <= '0;
         leds_en_ff     <= 1'b1;
         rx_on_ff       <= 1'b0;
         tx_on_ff       <= 1'b0;
      end else if (push) begin
         phase_ff       <= phase_in;
         id_hi_ff       <= id_hi_in;
         tick_ff        <= tick_in;
         frame_start_ff <= frame_start_in;
         rx_start_ff    <= rx_start_in;
         tx_start_ff    <= tx_start_in;
         en_start_ff    <= en_start_in;
         leds_en_ff     <= leds_en_in;
         rx_on_ff       <= rx_on_in;
         tx_on_ff       <= tx_on_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         board_id_ff      <= sfb_pkg::BOARD_ID_RESET;
         frame_timeout_ff <= sfb_pkg::FRAME_TIMEOUT_RESET;
         led_window_ff    <= sfb_pkg::LED_WINDOW_RESET;
         led_flash_ff     <= sfb_pkg::LED_FLASH_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            sfb_pkg::CSR_BOARD_ID:      board_id_ff      <= csr_wdata[3:0];
            sfb_pkg::CSR_FRAME_TIMEOUT: frame_timeout_ff <= csr_wdata;
            sfb_pkg::CSR_LED_WINDOW:    led_window_ff    <= csr_wdata;
            sfb_pkg::CSR_LED_FLASH:     led_flash_ff     <= csr_wdata;
            default:                    led_flash_ff     <= led_flash_ff;
         endcase
      end
   end

endmodule

### src/sfb_queue.sv
module sfb_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  sfb_pkg::job_type wr_data,
   input  logic             pop,
   output sfb_pkg::job_type rd_data,
   output logic             empty,
   output logic             full
);

   localparam int PW = sfb_pkg::QUEUE_PTR_W;
   localparam int CW = sfb_pkg::QUEUE_CNT_W;
   localparam logic [PW-1:0] LAST_SLOT = PW'(sfb_pkg::QUEUE_DEPTH - 1);

   sfb_pkg::job_type slot_ff [sfb_pkg::QUEUE_DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;

   assign empty   = (count_ff == '0);
   assign full    = (count_ff == CW'(sfb_pkg::QUEUE_DEPTH));
   assign rd_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_SLOT) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_SLOT) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

### src/sfb_back.sv
module sfb_back (
   input  logic             clock,
   input  logic             reset,
   input  sfb_pkg::job_type head,
   input  logic             empty,
   output logic             pop,
   input  logic             out_ready,
   output logic             out_valid,
   output sfb_pkg::rsp_type out_data
);

   localparam logic [sfb_pkg::HDR_CNT_W-1:0] HDR_LAST =
      sfb_pkg::HDR_CNT_W'(sfb_pkg::HDR_LEN - 1);

   logic                          valid_ff, valid_in;
   sfb_pkg::rsp_type              data_ff, data_in;
   logic [sfb_pkg::HDR_CNT_W-1:0] cnt_ff, cnt_in;
   logic                          load, done;

   assign load      = !empty && (!valid_ff || out_ready);
   assign done      = !head.multi || (cnt_ff == HDR_LAST);
   assign pop       = load && done;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_comb begin
      data_in.accepted   = head.accepted;
      data_in.byte_valid = head.byte_valid;
      data_in.out_dest   = head.out_dest;
      data_in.last       = done;
      data_in.rx_led_lit = head.rx_led_lit;
      data_in.tx_led_lit = head.tx_led_lit;
      data_in.out_byte   = head.out_byte;
      // A shield header becomes '(' '0' '0' and then the board id digit.
      if (head.multi) begin
         unique case (cnt_ff)
            2'd0:    data_in.out_byte = sfb_pkg::CHAR_LPAREN;
            2'd1:    data_in.out_byte = sfb_pkg::CHAR_ZERO;
            2'd2:    data_in.out_byte = sfb_pkg::CHAR_ZERO;
            default: data_in.out_byte = head.out_byte;
         endcase
      end
   end

   always_comb begin
      cnt_in   = cnt_ff;
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
         cnt_in   = done ? '0 : cnt_ff + 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= data_in;
      end
   end

endmodule
